>>> rtl/qnu_pkg.sv
// Shared types and constants of the quaternion normalizer.
// No dependencies; all other files of the block but qnu_if refer to this package.
package qnu_pkg;

	localparam int CompW  = 16;            // input component width
	localparam int NumC   = 4;             // components of a quaternion
	localparam int SqW    = 31;            // one square, at most 2^30
	localparam int SumW   = 34;            // sum of squares padded to an even width
	localparam int RootW  = SumW / 2;      // integer root, at most 2^16
	localparam int RemW   = RootW + 4;     // root remainder with two bits shifted in
	localparam int QuotW  = 15;            // quotient bits, result below 2^15
	localparam int FracW  = 14;            // Q1.14 fraction bits
	localparam int DRemW  = RootW + 1;     // divider partial remainder
	localparam int OneQ14 = 1 << FracW;

	typedef logic signed [CompW-1:0] comp_t;
	typedef comp_t [NumC-1:0] quad_t;

	typedef struct packed {
		logic signed [CompW-1:0] comp_w;
		logic signed [CompW-1:0] comp_x;
		logic signed [CompW-1:0] comp_y;
		logic signed [CompW-1:0] comp_z;
	} in_word_t;

	typedef struct packed {
		logic signed [CompW-1:0] norm_w;
		logic signed [CompW-1:0] norm_x;
		logic signed [CompW-1:0] norm_y;
		logic signed [CompW-1:0] norm_z;
		logic                    zero_length;
	} out_word_t;

endpackage

>>> rtl/qnu_if.sv
// Valid/ready channel that carries one word of a given payload type.
// Used by the top level of the quaternion normalizer for both channels.
interface qnu_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/qnu_sumsq.sv
// Two pipeline stages: squares of the four components, then their sum.
// Depends on qnu_pkg.
module qnu_sumsq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  qnu_pkg::quad_t                comp_i,
	output logic                          vld_o,
	output qnu_pkg::quad_t                comp_o,
	output logic [qnu_pkg::SumW-1:0]      sum_o,
	output logic                          zero_o
);
	logic [qnu_pkg::SqW-1:0]            sq_s1 [qnu_pkg::NumC];
	qnu_pkg::quad_t                     comp_s1;
	logic                               vld_s1;
	logic                               vld_s2;
	logic signed [2*qnu_pkg::CompW-1:0] prod [qnu_pkg::NumC];

	always_comb begin
		for (int i = 0; i < qnu_pkg::NumC; i++) begin
			prod[i] = comp_i[i] * comp_i[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < qnu_pkg::NumC; i++) begin
				sq_s1[i] <= prod[i][qnu_pkg::SqW-1:0];
			end
			comp_s1 <= comp_i;
			comp_o  <= comp_s1;
			sum_o   <= qnu_pkg::SumW'(sq_s1[0]) + qnu_pkg::SumW'(sq_s1[1])
			         + qnu_pkg::SumW'(sq_s1[2]) + qnu_pkg::SumW'(sq_s1[3]);
			zero_o  <= (comp_s1 == '0);
		end
	end

	assign vld_o = vld_s2;
endmodule

>>> rtl/qnu_sqrt.sv
// Digit-by-digit integer square root, one result bit per pipeline stage.
// The components and the zero flag ride along. Depends on qnu_pkg.
module qnu_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  qnu_pkg::quad_t                comp_i,
	input  logic [qnu_pkg::SumW-1:0]      sum_i,
	input  logic                          zero_i,
	output logic                          vld_o,
	output qnu_pkg::quad_t                comp_o,
	output logic [qnu_pkg::RootW-1:0]     root_o,
	output logic                          zero_o
);
	localparam int N = qnu_pkg::RootW;

	logic                          vld_s  [N+1];
	qnu_pkg::quad_t                comp_s [N+1];
	logic                          zero_s [N+1];
	logic [qnu_pkg::SumW-1:0]      rad_s  [N+1];
	logic [qnu_pkg::RemW-1:0]      rem_s  [N+1];
	logic [qnu_pkg::RootW-1:0]     root_s [N+1];

	assign vld_s[0]  = vld_i;
	assign comp_s[0] = comp_i;
	assign zero_s[0] = zero_i;
	assign rad_s[0]  = sum_i;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [qnu_pkg::RemW-1:0] rem_n;
		logic [qnu_pkg::RemW-1:0] trial;
		logic                     ge;

		always_comb begin
			rem_n = {rem_s[k][qnu_pkg::RemW-3:0], rad_s[k][qnu_pkg::SumW-1 -: 2]};
			trial = {2'b00, root_s[k], 2'b01};
			ge    = (rem_n >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				comp_s[k+1] <= comp_s[k];
				zero_s[k+1] <= zero_s[k];
				rad_s[k+1]  <= rad_s[k] << 2;
				rem_s[k+1]  <= ge ? rem_n - trial : rem_n;
				root_s[k+1] <= {root_s[k][qnu_pkg::RootW-2:0], ge};
			end
		end
	end

	assign vld_o  = vld_s[N];
	assign comp_o = comp_s[N];
	assign root_o = root_s[N];
	assign zero_o = zero_s[N];
endmodule

>>> rtl/qnu_div.sv
// Four restoring dividers in lockstep, one quotient bit per pipeline stage.
// Each lane divides |component| * 2^14 by the root. Depends on qnu_pkg.
module qnu_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          vld_i,
	input  qnu_pkg::quad_t                comp_i,
	input  logic [qnu_pkg::RootW-1:0]     root_i,
	input  logic                          zero_i,
	output logic                          vld_o,
	output logic [qnu_pkg::QuotW-1:0]     quot_o [qnu_pkg::NumC],
	output logic [qnu_pkg::NumC-1:0]      neg_o,
	output logic                          zero_o
);
	localparam int N = qnu_pkg::QuotW;

	logic                          vld_s  [N+1];
	logic                          zero_s [N+1];
	logic [qnu_pkg::RootW-1:0]     den_s  [N+1];
	logic [qnu_pkg::NumC-1:0]      neg_s  [N+1];
	logic [qnu_pkg::DRemW-1:0]     rem_s  [N+1][qnu_pkg::NumC];
	logic [N-1:0]                  low_s  [N+1][qnu_pkg::NumC];
	logic [N-1:0]                  quot_s [N+1][qnu_pkg::NumC];

	assign vld_s[0]  = vld_i;
	assign zero_s[0] = zero_i;
	assign den_s[0]  = root_i;

	// The dividend starts with |c| >> 1 as the partial remainder, which stays
	// below the root since |c| never exceeds it; the rest of |c| << 14 shifts in.
	for (genvar l = 0; l < qnu_pkg::NumC; l++) begin : g_lane
		logic [qnu_pkg::CompW-1:0] mag;
		always_comb begin
			mag = comp_i[l][qnu_pkg::CompW-1] ? qnu_pkg::CompW'(-comp_i[l])
			                                  : qnu_pkg::CompW'(comp_i[l]);
		end
		assign neg_s[0][l]  = comp_i[l][qnu_pkg::CompW-1];
		assign rem_s[0][l]  = qnu_pkg::DRemW'(mag >> 1);
		assign low_s[0][l]  = {mag[0], {(N-1){1'b0}}};
		assign quot_s[0][l] = '0;
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[k+1] <= zero_s[k];
				den_s[k+1]  <= den_s[k];
				neg_s[k+1]  <= neg_s[k];
			end
		end

		for (genvar l = 0; l < qnu_pkg::NumC; l++) begin : g_lane
			logic [qnu_pkg::DRemW-1:0] rem_n;
			logic                      ge;

			always_comb begin
				rem_n = {rem_s[k][l][qnu_pkg::DRemW-2:0], low_s[k][l][N-1]};
				ge    = (rem_n >= {1'b0, den_s[k]});
			end

			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1][l]  <= ge ? rem_n - {1'b0, den_s[k]} : rem_n;
					low_s[k+1][l]  <= low_s[k][l] << 1;
					quot_s[k+1][l] <= {quot_s[k][l][N-2:0], ge};
				end
			end
		end
	end

	assign vld_o  = vld_s[N];
	assign neg_o  = neg_s[N];
	assign zero_o = zero_s[N];
	for (genvar l = 0; l < qnu_pkg::NumC; l++) begin : g_out
		assign quot_o[l] = quot_s[N][l];
	end
endmodule

>>> rtl/quaternion_normalizer_unit.sv
// Quaternion normalizer: scales four Q3.12 components to a unit-length
// Q1.14 quaternion. Depends on qnu_pkg, qnu_if, qnu_sumsq, qnu_sqrt, qnu_div.
//
// Channels: sample (sink) takes one quaternion word per handshake; result
// (source) gives one normalized word per sample, in order. A sample whose
// components are all zero returns zeros with zero_length set.
// Pipeline from accepted sample to a valid result word: two stages for
// the squares and their sum, 17 square root stages (one root bit each),
// 15 divider stages (one quotient bit each) and the output register.
// Throughput: one word per cycle; a new sample is taken every cycle while
// the result side takes words.
// Stall: when the output register holds a word that is not taken, the whole
// pipeline freezes and sample.ready drops; nothing is lost or repeated.
// Reset: arst_n clears all valid bits at once; the block keeps no other state
// and can take a sample in the first cycle after reset.
module quaternion_normalizer_unit (
	input logic   clk,
	input logic   arst_n,
	qnu_if.sink   sample,
	qnu_if.source result
);
	logic                          en;
	qnu_pkg::quad_t                comp_in;

	logic                          vld_a;
	qnu_pkg::quad_t                comp_a;
	logic [qnu_pkg::SumW-1:0]      sum_a;
	logic                          zero_a;

	logic                          vld_b;
	qnu_pkg::quad_t                comp_b;
	logic [qnu_pkg::RootW-1:0]     root_b;
	logic                          zero_b;

	logic                          vld_c;
	logic [qnu_pkg::QuotW-1:0]     quot_c [qnu_pkg::NumC];
	logic [qnu_pkg::NumC-1:0]      neg_c;
	logic                          zero_c;

	logic                          vld_q;
	qnu_pkg::out_word_t            word_q;
	qnu_pkg::comp_t                norm   [qnu_pkg::NumC];

	assign en           = !vld_q || result.ready;
	assign sample.ready = en;
	assign comp_in      = {sample.data.comp_z, sample.data.comp_y,
	                       sample.data.comp_x, sample.data.comp_w};

	qnu_sumsq u_sumsq (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (sample.valid),
		.comp_i (comp_in),
		.vld_o  (vld_a),
		.comp_o (comp_a),
		.sum_o  (sum_a),
		.zero_o (zero_a)
	);

	qnu_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_a),
		.comp_i (comp_a),
		.sum_i  (sum_a),
		.zero_i (zero_a),
		.vld_o  (vld_b),
		.comp_o (comp_b),
		.root_o (root_b),
		.zero_o (zero_b)
	);

	qnu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (vld_b),
		.comp_i (comp_b),
		.root_i (root_b),
		.zero_i (zero_b),
		.vld_o  (vld_c),
		.quot_o (quot_c),
		.neg_o  (neg_c),
		.zero_o (zero_c)
	);

	// Clamp, restore the sign, and force zeros for a zero-length quaternion.
	always_comb begin
		for (int i = 0; i < qnu_pkg::NumC; i++) begin
			logic [qnu_pkg::CompW-1:0] mag;
			mag = (quot_c[i] > qnu_pkg::QuotW'(qnu_pkg::OneQ14))
			    ? qnu_pkg::CompW'(qnu_pkg::OneQ14)
			    : qnu_pkg::CompW'(quot_c[i]);
			if (zero_c) begin
				norm[i] = '0;
			end else if (neg_c[i]) begin
				norm[i] = qnu_pkg::comp_t'(-mag);
			end else begin
				norm[i] = qnu_pkg::comp_t'(mag);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_q.norm_w      <= norm[0];
			word_q.norm_x      <= norm[1];
			word_q.norm_y      <= norm[2];
			word_q.norm_z      <= norm[3];
			word_q.zero_length <= zero_c;
		end
	end

	assign result.valid = vld_q;
	assign result.data  = word_q;

`ifndef SYNTHESIS
	a_zero_gives_zeros: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.zero_length |->
		result.data.norm_w == 0 && result.data.norm_x == 0 &&
		result.data.norm_y == 0 && result.data.norm_z == 0)
		else $error("zero-length word carries nonzero components");

	a_range_w: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> result.data.norm_w <= 16384 && result.data.norm_w >= -16384)
		else $error("norm_w out of Q1.14 unit range");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |-> !sample.ready)
		else $error("sample taken while the output word is stalled");
`endif
endmodule

>>> bench/tb.sv
// Testbench of the quaternion normalizer: directed and random quaternions,
// checked against a fixed-point model. Depends on qnu_pkg, qnu_if and the RTL.
`timescale 1ns / 1ps

module tb;

	logic clk;
	logic arst_n;
	qnu_if #(.T(qnu_pkg::in_word_t))  sample ();
	qnu_if #(.T(qnu_pkg::out_word_t)) result ();

	quaternion_normalizer_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.result (result)
	);

	qnu_pkg::out_word_t expected_words[$];
	int        errors;
	int        sent;
	int        checked;
	int        zero_seen;
	int        cycles;
	bit        hold_result;
	bit        long_hold;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Floor square root by the shift-and-subtract method.
	function automatic longint unsigned root_floor(longint unsigned s);
		longint unsigned rem;
		longint unsigned root;
		longint unsigned bitv;
		rem  = s;
		root = 0;
		bitv = 64'd1 << 32;
		while (bitv > rem) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem  = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic signed [15:0] scale_comp(logic signed [15:0] c,
			longint unsigned len);
		longint unsigned mag;
		longint unsigned q;
		mag = (c < 0) ? longint'(-longint'(c)) : longint'(c);
		q   = (mag * qnu_pkg::OneQ14) / len;
		if (q > qnu_pkg::OneQ14) q = qnu_pkg::OneQ14;
		return (c < 0) ? -16'(q) : 16'(q);
	endfunction

	function automatic qnu_pkg::out_word_t normalize(qnu_pkg::in_word_t w);
		qnu_pkg::out_word_t o;
		longint unsigned    s;
		longint unsigned    len;
		s = longint'(w.comp_w) * w.comp_w + longint'(w.comp_x) * w.comp_x
			+ longint'(w.comp_y) * w.comp_y + longint'(w.comp_z) * w.comp_z;
		o = '0;
		if (s == 0) begin
			o.zero_length = 1'b1;
		end else begin
			len = root_floor(s);
			o.norm_w = scale_comp(w.comp_w, len);
			o.norm_x = scale_comp(w.comp_x, len);
			o.norm_y = scale_comp(w.comp_y, len);
			o.norm_z = scale_comp(w.comp_z, len);
		end
		return o;
	endfunction

	task automatic report(string what, int got, int want);
		errors++;
		$display("mismatch word %0d %s: got %0d want %0d", checked, what, got, want);
	endtask

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
			logic signed [15:0] y, logic signed [15:0] z);
		qnu_pkg::in_word_t word;
		int                g;
		word = '{comp_w: w, comp_x: x, comp_y: y, comp_z: z};
		expected_words.push_back(normalize(word));
		sample.valid <= 1'b1;
		sample.data  <= word;
		@(posedge clk);
		while (!sample.ready) @(posedge clk);
		sent++;
		g = gap_len();
		if (g > 0) begin
			sample.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic logic signed [15:0] rand_comp();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'sh8000;
		if (r == 1) return 16'sh7fff;
		if (r == 2) return 16'(signed'($urandom_range(0, 15)) - 8);
		return 16'($urandom);
	endfunction

	task automatic test_directed();
		send_quat(0, 0, 0, 0);
		send_quat(4096, 0, 0, 0);
		send_quat(0, -4096, 0, 0);
		send_quat(0, 0, 32767, 0);
		send_quat(0, 0, 0, -32768);
		send_quat(-32768, -32768, -32768, -32768);
		send_quat(32767, 32767, 32767, 32767);
		send_quat(32767, -32768, 32767, -32768);
		send_quat(1, 0, 0, 0);
		send_quat(-1, 0, 0, 0);
		send_quat(1, 1, 1, 1);
		send_quat(-1, 1, -1, 1);
		send_quat(0, 0, 0, 0);
		send_quat(2048, 2048, 2048, 2048);
		send_quat(3, 4, 0, 0);
		send_quat(-21845, 21845, 1, -1);
	endtask

	task automatic test_random(int n);
		repeat (n) begin
			if ($urandom_range(0, 49) == 0) send_quat(0, 0, 0, 0);
			else send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
		end
	endtask

	// Holds the result side off for a long stretch so the pipeline fills.
	task automatic test_backpressure();
		long_hold = 1'b1;
		test_random(80);
		long_hold = 1'b0;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (expected_words.size() == 0) begin
					report("unexpected", 0, 0);
				end else begin
					automatic qnu_pkg::out_word_t e = expected_words.pop_front();
					if (result.data.norm_w != e.norm_w)
						report("norm_w", result.data.norm_w, e.norm_w);
					if (result.data.norm_x != e.norm_x)
						report("norm_x", result.data.norm_x, e.norm_x);
					if (result.data.norm_y != e.norm_y)
						report("norm_y", result.data.norm_y, e.norm_y);
					if (result.data.norm_z != e.norm_z)
						report("norm_z", result.data.norm_z, e.norm_z);
					if (result.data.zero_length != e.zero_length)
						report("zero_length", result.data.zero_length, e.zero_length);
					if (e.zero_length) zero_seen++;
				end
				checked++;
			end
		end
	end

	// Receiver stalls: random short and long gaps, plus one long hold-off.
	initial begin
		int g;
		result.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				result.ready <= 1'b0;
				repeat (200) @(posedge clk);
				result.ready <= 1'b1;
				@(posedge clk);
				while (long_hold) @(posedge clk);
			end else begin
				g = hold_result ? gap_len() : 0;
				if (g > 0) begin
					result.ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
				result.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		sample.valid = 1'b0;
		sample.data  = '0;
		hold_result  = 1'b0;
		long_hold    = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		hold_result = 1'b1;
		test_random(900);
		hold_result = 1'b0;
		test_random(300);
		hold_result = 1'b1;
		test_random(600);
		sample.valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		$display("Sent %0d quaternions, checked %0d results, %0d of zero length.",
			sent, checked, zero_seen);
		if (errors == 0 && expected_words.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> sim.f
rtl/qnu_pkg.sv
rtl/qnu_if.sv
rtl/qnu_sumsq.sv
rtl/qnu_sqrt.sv
rtl/qnu_div.sv
rtl/quaternion_normalizer_unit.sv
bench/tb.sv
